[design/ipv4dq_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Character codes, limits and the running state type used by the dotted-quad
// address checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4dq_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // limits
  localparam int unsigned FIELD_VAL_W  = 9;
  localparam int unsigned FIELD_CNT_W  = 3;
  localparam int unsigned ACC_W        = 12;
  localparam logic [FIELD_VAL_W-1:0] FIELD_VAL_SAT = 9'd256;
  localparam logic [FIELD_CNT_W-1:0] FIELD_CNT_SAT = 3'd7;
  localparam logic [FIELD_CNT_W-1:0] FIELDS_NEEDED = 3'd4;

  // running state carried from one character to the next
  typedef struct packed {
    logic [FIELD_VAL_W-1:0] field_value;
    logic                   in_field;
    logic [FIELD_CNT_W-1:0] field_count;
    logic                   bad;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_CLR = '0;

endpackage

[design/ipv4_dotted_quad_checker.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Streams an address string in byte by byte and flags whether it is a valid
// dotted IPv4 address when the terminating zero byte arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready / in_ch carries one character per
//   request. Only the zero byte produces a result request on out_valid /
//   out_ready / out_valid_res; every other character just updates the
//   running scan state (field value, field count, error flag).
//   The result is registered and appears in the cycle after the zero
//   byte is accepted. Throughput: one character per cycle unless the receiver
//   stalls, set by the single pass of digit-accumulate and field-close logic
//   into the state registers. A new character is taken while the output register
//   is empty or is being emptied in the same cycle, so back-to-back strings run
//   without gaps. When the receiver stalls with a result pending, in_ready drops
//   and the input waits; the result holds until taken.
//   Reset (rst_n low, synchronous) clears the scan state and the output valid
//   flag; the result payload register is not reset. The scan state also returns
//   to its cleared value after each terminator, ready for the next string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_dotted_quad_checker
  import ipv4dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_valid_res
);

  scan_state_t st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_valid_res_r, out_valid_res_nxt;

  logic                   in_acc;
  logic                   is_nul, is_dot, is_digit;
  logic [ACC_W-1:0]       acc_sum;
  logic [FIELD_VAL_W-1:0] digit_val;
  logic                   close_bad;
  logic [FIELD_CNT_W-1:0] close_cnt;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // character classes
  assign is_nul   = (in_ch == CHAR_NUL);
  assign is_dot   = (in_ch == CHAR_DOT);
  assign is_digit = (in_ch >= CHAR_ZERO) && (in_ch <= CHAR_NINE);

  // value * 10 + digit, saturating at 256
  assign acc_sum = {st_r.field_value, 3'b000} + {2'b00, st_r.field_value, 1'b0}
                 + ACC_W'(in_ch - CHAR_ZERO);
  assign digit_val = (acc_sum > ACC_W'(FIELD_VAL_SAT)) ? FIELD_VAL_SAT
                                                       : acc_sum[FIELD_VAL_W-1:0];

  // closing the current field
  assign close_bad = st_r.bad || (st_r.in_field && (st_r.field_value > 9'd255));
  assign close_cnt = (st_r.in_field && (st_r.field_count != FIELD_CNT_SAT))
                   ? st_r.field_count + 3'd1 : st_r.field_count;

  // next scan state and result
  always_comb begin
    st_nxt            = st_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_valid_res_nxt = out_valid_res_r;
    if (in_acc) begin
      priority if (is_nul) begin
        st_nxt            = SCAN_STATE_CLR;
        out_valid_nxt     = 1'b1;
        out_valid_res_nxt = !close_bad && (close_cnt == FIELDS_NEEDED);
      end else if (is_dot) begin
        st_nxt.bad         = close_bad;
        st_nxt.field_count = close_cnt;
        st_nxt.in_field    = 1'b0;
        st_nxt.field_value = '0;
      end else if (is_digit) begin
        st_nxt.in_field    = 1'b1;
        st_nxt.field_value = digit_val;
      end else begin
        st_nxt.in_field = 1'b1;
        st_nxt.bad      = 1'b1;
      end
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SCAN_STATE_CLR;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_valid_res_r <= out_valid_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;

  // checks
  a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_nul) |=> (st_r == SCAN_STATE_CLR) && out_valid_r)
    else $error("scan state not cleared after terminator");

  a_no_result_on_char: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_nul && !out_valid_r) |=> !out_valid_r)
    else $error("result raised by non-terminator character");

  a_value_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.field_value <= FIELD_VAL_SAT)
    else $error("field value beyond saturation");

  a_empty_field: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_field |-> (st_r.field_value == '0))
    else $error("field value held outside a field");

endmodule

[tb/sv/ipv4_dotted_quad_checker_test.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker_test
// Streams address strings into the dotted-quad checker one character per
// request and compares each verdict with a local scan of the same characters.
// Directed strings cover the edge cases. Random addresses and junk strings
// then run under several sender idle and receiver stall settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_dotted_quad_checker_test;
  import ipv4dq_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_ch;
  logic       out_valid;
  logic       out_ready;
  logic       out_valid_res;

  // idle and stall chances in percent, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          mismatch_count;

  // local copy of the scan state and verdicts still to arrive
  scan_state_t scan = SCAN_STATE_CLR;
  logic        verdict_q[$];
  logic [7:0]  text_buf[$];

  ipv4_dotted_quad_checker uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // end of a field: range check and saturating count
  function automatic void close_field();
    if (scan.in_field) begin
      if (scan.field_value > 9'd255) scan.bad = 1'b1;
      if (scan.field_count != FIELD_CNT_SAT) scan.field_count = scan.field_count + 3'd1;
    end
    scan.in_field    = 1'b0;
    scan.field_value = '0;
  endfunction

  // advance the scan by one character, returns 1 when a verdict is due
  function automatic logic scan_char(input logic [7:0] c, output logic verdict);
    int unsigned acc;
    scan_char = 1'b0;
    verdict   = 1'b0;
    if (c == CHAR_NUL) begin
      close_field();
      verdict   = !scan.bad && scan.field_count == FIELDS_NEEDED;
      scan      = SCAN_STATE_CLR;
      scan_char = 1'b1;
    end else if (c == CHAR_DOT) begin
      close_field();
    end else begin
      scan.in_field = 1'b1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        acc = int'(scan.field_value) * 10 + int'(c - CHAR_ZERO);
        scan.field_value = (acc > FIELD_VAL_SAT) ? FIELD_VAL_SAT : acc[8:0];
      end else begin
        scan.bad = 1'b1;
      end
    end
  endfunction

  // one character request, with a random idle gap ahead of it
  task automatic send_char(input logic [7:0] c);
    logic verdict;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_ch    <= 8'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (scan_char(c, verdict)) verdict_q.push_back(verdict);
  endtask

  // buffered string plus its terminator
  task automatic send_string();
    foreach (text_buf[i]) send_char(text_buf[i]);
    send_char(CHAR_NUL);
  endtask

  task automatic send_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_string();
  endtask

  // sender goes quiet until every verdict is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // random address, mostly well formed, sometimes broken
  task automatic build_address();
    int    n_fields;
    int    v;
    string digits;
    text_buf.delete();
    case ($urandom_range(9))
      0:       n_fields = $urandom_range(0, 3);
      1:       n_fields = $urandom_range(5, 10);
      default: n_fields = 4;
    endcase
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_DOT);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) begin
        text_buf.push_back(CHAR_DOT);
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_DOT);
      end
      case ($urandom_range(7))
        0:       v = $urandom_range(0, 9);
        6:       v = $urandom_range(250, 260);
        7:       v = $urandom_range(256, 2000000000);
        default: v = $urandom_range(0, 255);
      endcase
      if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_ZERO);
      digits = $sformatf("%0d", v);
      for (int i = 0; i < digits.len(); i++) text_buf.push_back(digits[i]);
    end
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_DOT);
    // stray character somewhere in the string
    if ($urandom_range(7) == 0 && text_buf.size() > 0)
      text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(1, 255));
  endtask

  // edge cases: extremes, dot runs, field count limits, stray characters
  task automatic test_directed_strings();
    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("256.1.1.1");
    send_text("");
    send_text("...");
    send_text(".1..2...3.4.");
    send_text("1.2.3");
    send_text("1.2.3.4.5.6.7.8.9");
    send_text("00012.3.4.5");
    send_text("1.2.3.99999999999999");
    send_text("1/2.3.4");
    send_text("1.2:.3.4");
    send_text("1.2.3.4");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h80);
    send_string();
  endtask

  task automatic test_random_addresses(input int n_strings);
    repeat (n_strings) begin
      build_address();
      send_string();
    end
  endtask

  // junk strings mixing digits, dots and any other byte
  task automatic test_junk_strings(input int n_strings);
    repeat (n_strings) begin
      text_buf.delete();
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(3))
          0:       text_buf.push_back(CHAR_DOT);
          1:       text_buf.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
          default: text_buf.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      send_string();
    end
  endtask

  // a gap in the input while results are still pending
  task automatic test_pause_until_drained();
    repeat (3) begin
      build_address();
      send_string();
      drain_results();
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin : result_check
    logic want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual out_valid_res=%0b",
                   $time, out_valid_res);
        end else begin
          want = verdict_q.pop_front();
          if (out_valid_res !== want) begin
            mismatch_count++;
            $display("%0t: out_valid_res mismatch: expected %0b, actual %0b",
                     $time, want, out_valid_res);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_valid       = 1'b0;
    in_ch          = 8'h00;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no idling
    test_directed_strings();
    test_random_addresses(13);
    test_junk_strings(4);

    // sender mostly idle
    send_idle_pct = 87;
    test_random_addresses(13);
    test_junk_strings(4);

    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    test_random_addresses(11);
    test_pause_until_drained();
    test_junk_strings(4);

    // both sides idle now and then
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    test_random_addresses(13);
    test_junk_strings(4);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
